/* rtl/core/cgd_pkg.sv */
`default_nettype none

package cgd_pkg;

    // Depth of the queue between the classifier and the executor
    localparam int unsigned CGD_QUEUE_DEPTH = 2;

    localparam logic [11:0] CENTER_POS  = 12'd1904;
    localparam logic [11:0] PHOTO_X     = 12'd1536;
    localparam logic [11:0] PHOTO_Y     = 12'd608;
    localparam logic [11:0] LONG_X      = 12'd2048;
    localparam logic [11:0] LONG_UP_Y   = 12'd784;
    localparam logic [11:0] LONG_DOWN_Y = 12'd2912;

    localparam logic [23:0] GAP_RESET = 24'd1300000;

    localparam logic [9:0] PEN_CODE      = 10'd320;
    localparam logic [9:0] VOL_DOWN_CODE = 10'd114;
    localparam logic [9:0] VOL_UP_CODE   = 10'd115;

    localparam logic [1:0] MODE_X   = 2'd0;
    localparam logic [1:0] MODE_Y   = 2'd1;
    localparam logic [1:0] MODE_KEY = 2'd2;

    localparam logic [11:0] KEY_PRESS = 12'd1;

    typedef logic [3:0] action_t;

    localparam action_t ACT_UP         = 4'd0;
    localparam action_t ACT_DOWN       = 4'd1;
    localparam action_t ACT_LEFT       = 4'd2;
    localparam action_t ACT_RIGHT      = 4'd3;
    localparam action_t ACT_ENTER      = 4'd4;
    localparam action_t ACT_PHOTO      = 4'd5;
    localparam action_t ACT_LONG_UP    = 4'd6;
    localparam action_t ACT_LONG_DOWN  = 4'd7;
    localparam action_t ACT_LONG_LEFT  = 4'd8;
    localparam action_t ACT_LONG_RIGHT = 4'd9;

    typedef enum logic [1:0] {
        EV_X,
        EV_Y,
        EV_KEY
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [11:0] value;
        logic        is_pen;
        logic        is_vol_down;
        logic        is_vol_up;
        logic        is_press;
        logic [39:0] now;
    } cgd_item_t;

endpackage

`default_nettype wire

/* rtl/core/cgd_front.sv */
`default_nettype none

module cgd_front (
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [11:0]        value,
    input  wire logic [9:0]         key_code,
    input  wire logic [39:0]        timestamp_us,
    input  wire logic               q_full,
    output logic                    push,
    output cgd_pkg::cgd_item_t      push_item
);
    import cgd_pkg::*;

    logic known;

    // classify the item; unused mode codes are taken and dropped here
    always_comb
    begin
        known          = 1'b1;
        push_item.kind = EV_KEY;
        unique case (mode)
            MODE_X:   push_item.kind = EV_X;
            MODE_Y:   push_item.kind = EV_Y;
            MODE_KEY: push_item.kind = EV_KEY;
            default:  known = 1'b0;
        endcase
        push_item.value       = value;
        push_item.is_pen      = (key_code == PEN_CODE);
        push_item.is_vol_down = (key_code == VOL_DOWN_CODE);
        push_item.is_vol_up   = (key_code == VOL_UP_CODE);
        push_item.is_press    = (value == KEY_PRESS);
        push_item.now         = timestamp_us;
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && known;

endmodule

`default_nettype wire

/* rtl/core/cgd_queue.sv */
`default_nettype none

module cgd_queue #(
    parameter int unsigned DEPTH = cgd_pkg::CGD_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire cgd_pkg::cgd_item_t push_item,
    output logic                    full,
    output logic                    q_valid,
    output cgd_pkg::cgd_item_t      q_item,
    input  wire logic               pop
);
    import cgd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    cgd_item_t     entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full    = (count_reg == FULL_COUNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !q_valid))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

/* rtl/core/cgd_back.sv */
`default_nettype none

module cgd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire cgd_pkg::cgd_item_t q_item,
    output logic                    pop,
    input  wire logic               cfg_we,
    input  wire logic [23:0]        cfg_wdata,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cgd_pkg::action_t        action
);
    import cgd_pkg::*;

    typedef enum logic [2:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    logic [11:0] x_reg, x_next;
    logic [11:0] y_reg, y_next;
    logic [11:0] level_reg, level_next;
    dir_t        dir_reg, dir_next;
    logic [1:0]  latch_reg, latch_next;
    logic [39:0] time_reg [2];
    logic [1:0]  time_we;
    logic [23:0] gap_reg;
    logic        out_valid_reg, out_valid_next;
    action_t     action_reg;

    logic        ready;
    logic        emit;
    action_t     emit_action;
    logic [1:0]  key_match;
    logic [39:0] then_time;
    logic [40:0] diff;
    logic        elapsed;

    assign ready = !out_valid_reg || !out_stall;
    assign pop   = q_valid && ready;

    // only the pressed volume key needs its gap; a borrow means not elapsed
    assign key_match = {q_item.is_vol_up, q_item.is_vol_down};
    assign then_time = time_reg[q_item.is_vol_up];
    assign diff      = {1'b0, q_item.now} - {1'b0, then_time};
    assign elapsed   = !diff[40] && (diff[39:0] >= {16'd0, gap_reg});

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        level_next  = level_reg;
        dir_next    = dir_reg;
        latch_next  = latch_reg;
        time_we     = 2'b00;
        emit        = 1'b0;
        emit_action = ACT_UP;
        if (pop)
        begin
            unique case (q_item.kind)
                EV_X:
                begin
                    if (level_reg != '0)
                    begin
                        if (q_item.value > x_reg)
                            dir_next = DIR_LEFT;
                        else if (q_item.value < x_reg)
                            dir_next = DIR_RIGHT;
                    end
                    x_next = q_item.value;
                end
                EV_Y:
                begin
                    if (level_reg != '0)
                    begin
                        if (q_item.value > y_reg)
                            dir_next = DIR_UP;
                        else if (q_item.value < y_reg)
                            dir_next = DIR_DOWN;
                    end
                    y_next = q_item.value;
                    if (x_reg == LONG_X && level_reg != '0)
                    begin
                        if (q_item.value == LONG_UP_Y)
                        begin
                            emit        = 1'b1;
                            emit_action = ACT_LONG_UP;
                        end
                        else if (q_item.value == LONG_DOWN_Y)
                        begin
                            emit        = 1'b1;
                            emit_action = ACT_LONG_DOWN;
                        end
                    end
                end
                EV_KEY:
                begin
                    if (q_item.is_pen && q_item.value != level_reg)
                    begin
                        level_next = q_item.value;
                        if (q_item.value != '0)
                        begin
                            dir_next = DIR_NONE;
                        end
                        else
                        begin
                            emit = 1'b1;
                            if (x_reg == CENTER_POS && y_reg == CENTER_POS)
                                emit_action = ACT_ENTER;
                            else if (x_reg == PHOTO_X && y_reg == PHOTO_Y)
                                emit_action = ACT_PHOTO;
                            else if (dir_reg == DIR_RIGHT)
                                emit_action = ACT_RIGHT;
                            else if (dir_reg == DIR_LEFT)
                                emit_action = ACT_LEFT;
                            else if (x_reg != LONG_X && dir_reg == DIR_UP)
                                emit_action = ACT_UP;
                            else if (x_reg != LONG_X && dir_reg == DIR_DOWN)
                                emit_action = ACT_DOWN;
                            else
                                emit = 1'b0;
                        end
                    end
                    if (q_item.is_press)
                    begin
                        for (int k = 0; k < 2; k++)
                        begin
                            if (key_match[k])
                            begin
                                if (!(latch_reg[k] && !elapsed) && !emit)
                                begin
                                    emit        = 1'b1;
                                    emit_action = k[0] ? ACT_LONG_RIGHT : ACT_LONG_LEFT;
                                end
                                latch_next[k] = 1'b1;
                                time_we[k]    = 1'b1;
                            end
                            else
                            begin
                                latch_next[k] = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        out_valid_next = out_valid_reg;
        if (ready)
        begin
            out_valid_next = pop && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg         <= CENTER_POS;
            y_reg         <= CENTER_POS;
            level_reg     <= '0;
            dir_reg       <= DIR_NONE;
            latch_reg     <= '0;
            gap_reg       <= GAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            x_reg         <= x_next;
            y_reg         <= y_next;
            level_reg     <= level_next;
            dir_reg       <= dir_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                gap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (time_we[k])
            begin
                time_reg[k] <= q_item.now;
            end
        end
        if (pop && emit)
        begin
            action_reg <= emit_action;
        end
    end

    assign out_valid = out_valid_reg;
    assign action    = action_reg;

`ifndef NO_ASSERTIONS
    a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (action_reg <= ACT_LONG_RIGHT))
        else $error("action out of range");
    a_latch_one_key: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(latch_reg))
        else $error("both volume latches armed");
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(action_reg)))
        else $error("action changed while stalled");
`endif

endmodule

`default_nettype wire

/* rtl/core/clicker_gesture_decoder.sv */
// Path: an item taken is written into the queue; the executor pops it and registers its action.
// Throughput: one item per cycle while the result side is free; the classifier is
// combinational, the queue and the executor each register one item per cycle.
// A stalled action holds the executor; once both queue entries fill, the input stalls.
// Reset (rst_n low, asynchronous): queue empty, no action pending, position 1904/1904,
// button released, no direction, volume latches clear, gap register 1300000 us.
`default_nettype none

module clicker_gesture_decoder #(
    parameter int unsigned QUEUE_DEPTH = cgd_pkg::CGD_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input item channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         mode,
    input  wire logic [11:0]        value,
    input  wire logic [9:0]         key_code,
    input  wire logic [39:0]        timestamp_us,
    // result item channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output cgd_pkg::action_t        action,
    // long-repeat gap register, write only
    input  wire logic               cfg_we,
    input  wire logic [23:0]        cfg_wdata
);
    import cgd_pkg::*;

    logic      push;
    cgd_item_t push_item;
    logic      q_full;
    logic      q_valid;
    cgd_item_t q_item;
    logic      pop;

    // Front: take each item and classify it (position axis, pen key, volume key,
    // press); drop unused mode codes so they never reach the executor.
    cgd_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .value        (value),
        .key_code     (key_code),
        .timestamp_us (timestamp_us),
        .q_full       (q_full),
        .push         (push),
        .push_item    (push_item)
    );

    // Queue: hold classified items so input acceptance is not tied to the
    // result side; stall the input only when it is full.
    cgd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    // Back: advance the gesture state one item per cycle, and register the
    // action; pop only when the output register is free or being emptied.
    cgd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .action    (action)
    );

endmodule

`default_nettype wire

/* tb/sv/cgd_action_checker.sv */
`timescale 1ns / 1ps

module cgd_action_checker (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire logic [1:0]       mode,
    input  wire logic [11:0]      value,
    input  wire logic [9:0]       key_code,
    input  wire logic [39:0]      timestamp_us,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire cgd_pkg::action_t action,
    input  wire logic             cfg_we,
    input  wire logic [23:0]      cfg_wdata,
    output int                    failures,
    output int                    pending
);
    import cgd_pkg::*;

    typedef enum logic [2:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } move_dir_t;

    logic [23:0] gap_us;
    logic [11:0] x_pos;
    logic [11:0] y_pos;
    logic [11:0] pen_level;
    move_dir_t   move_dir;
    logic [1:0]  vol_latch;
    logic [39:0] vol_time [2];
    action_t     expected_actions [$];
    int          mismatches = 0;

    // a clock that steps back never counts as the gap having passed
    function automatic bit gap_passed(input logic [39:0] stamp_us, input logic [39:0] now_us);
        if (now_us < stamp_us)
            return 1'b0;
        return (now_us - stamp_us) >= {16'd0, gap_us};
    endfunction

    task automatic decode_event(
        input  logic [1:0]  ev_mode,
        input  logic [11:0] ev_value,
        input  logic [9:0]  ev_code,
        input  logic [39:0] ev_time,
        output bit          fired,
        output action_t     act
    );
        logic [9:0] vol_key [2];
        action_t    vol_act [2];
        vol_key[0] = VOL_DOWN_CODE;
        vol_key[1] = VOL_UP_CODE;
        vol_act[0] = ACT_LONG_LEFT;
        vol_act[1] = ACT_LONG_RIGHT;
        fired = 1'b0;
        act = ACT_UP;
        case (ev_mode)
            MODE_X:
            begin
                // reversed mapping: X rising reads as left
                if (pen_level != 0) begin
                    if (ev_value > x_pos) move_dir = DIR_LEFT;
                    if (ev_value < x_pos) move_dir = DIR_RIGHT;
                end
                x_pos = ev_value;
            end
            MODE_Y:
            begin
                if (pen_level != 0) begin
                    if (ev_value > y_pos) move_dir = DIR_UP;
                    if (ev_value < y_pos) move_dir = DIR_DOWN;
                end
                y_pos = ev_value;
                if (x_pos == LONG_X && pen_level != 0) begin
                    if (y_pos == LONG_UP_Y) begin
                        act = ACT_LONG_UP;
                        fired = 1'b1;
                    end else if (y_pos == LONG_DOWN_Y) begin
                        act = ACT_LONG_DOWN;
                        fired = 1'b1;
                    end
                end
            end
            MODE_KEY:
            begin
                if (ev_code == PEN_CODE && ev_value != pen_level) begin
                    pen_level = ev_value;
                    fired = 1'b1;
                    if (pen_level != 0) begin
                        move_dir = DIR_NONE;
                        fired = 1'b0;
                    end else if (x_pos == CENTER_POS && y_pos == CENTER_POS)
                        act = ACT_ENTER;
                    else if (x_pos == PHOTO_X && y_pos == PHOTO_Y)
                        act = ACT_PHOTO;
                    else if (move_dir == DIR_RIGHT)
                        act = ACT_RIGHT;
                    else if (move_dir == DIR_LEFT)
                        act = ACT_LEFT;
                    else if (x_pos != LONG_X && move_dir == DIR_UP)
                        act = ACT_UP;
                    else if (x_pos != LONG_X && move_dir == DIR_DOWN)
                        act = ACT_DOWN;
                    else
                        fired = 1'b0;
                end
                if (ev_value == KEY_PRESS) begin
                    for (int k = 0; k < 2; k++) begin
                        if (vol_latch[k] &&
                            (ev_code != vol_key[k] || gap_passed(vol_time[k], ev_time)))
                            vol_latch[k] = 1'b0;
                        if (ev_code == vol_key[k]) begin
                            if (!vol_latch[k] && !fired) begin
                                act = vol_act[k];
                                fired = 1'b1;
                            end
                            vol_latch[k] = 1'b1;
                            vol_time[k] = ev_time;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin : track_events
        bit      fired;
        action_t predicted;
        action_t oldest;
        if (!rst_n) begin
            gap_us = GAP_RESET;
            x_pos = CENTER_POS;
            y_pos = CENTER_POS;
            pen_level = '0;
            move_dir = DIR_NONE;
            vol_latch = '0;
            vol_time[0] = '0;
            vol_time[1] = '0;
            expected_actions.delete();
            pending <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_actions.size() == 0) begin
                    $error("action: expected none, got %0d", action);
                    mismatches++;
                end else begin
                    oldest = expected_actions.pop_front();
                    if (action !== oldest) begin
                        $error("action: expected %0d, got %0d", oldest, action);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
                gap_us = cfg_wdata;
            if (in_valid && !in_stall) begin
                decode_event(mode, value, key_code, timestamp_us, fired, predicted);
                if (fired)
                    expected_actions.push_back(predicted);
            end
            pending <= expected_actions.size();
        end
        failures <= mismatches;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import cgd_pkg::*;

    // Mode 3 is left unused by the block: it must swallow such items silently
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam logic [11:0] KEY_RELEASE  = 12'd0;
    localparam logic [11:0] KEY_REPEAT   = 12'd2;

    localparam int RANDOM_EVENTS    = 1300;
    localparam int PHASES           = 6;
    // Drain time for the queue and the executor's output register, with margin to spare
    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 400000;

    logic             clk;
    logic             rst_n        = 1'b0;
    logic             in_valid     = 1'b0;
    logic             in_stall;
    logic [1:0]       mode         = '0;
    logic [11:0]      value        = '0;
    logic [9:0]       key_code     = '0;
    logic [39:0]      timestamp_us = '0;
    logic             out_valid;
    logic             out_stall    = 1'b0;
    action_t          action;
    logic             cfg_we       = 1'b0;
    logic [23:0]      cfg_wdata    = '0;

    int               failures;
    int               pending;

    // Stimulus bookkeeping: idle ranges per side, the event clock, the last positions sent
    int               send_idle_max = 8;
    int               sink_idle_max = 8;
    bit               hold_results  = 1'b0;
    int               events_sent   = 0;
    logic [39:0]      now_us        = '0;
    logic [11:0]      last_x        = CENTER_POS;
    logic [11:0]      last_y        = CENTER_POS;

    clicker_gesture_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .value        (value),
        .key_code     (key_code),
        .timestamp_us (timestamp_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    cgd_action_checker action_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .value        (value),
        .key_code     (key_code),
        .timestamp_us (timestamp_us),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .action       (action),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .failures     (failures),
        .pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: give up once the cycle budget is spent
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one item and hold it until the block takes it. An idle gap of random
    // length goes in front; valid drops only when the gap is not empty.
    task automatic send_event(
        input logic [1:0]  ev_mode,
        input logic [11:0] ev_value,
        input logic [9:0]  ev_code,
        input logic [39:0] ev_time
    );
        int idle_cycles;
        idle_cycles = $urandom_range(0, send_idle_max);
        if (idle_cycles > 0) begin
            in_valid <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= ev_mode;
        value        <= ev_value;
        key_code     <= ev_code;
        timestamp_us <= ev_time;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (ev_mode != MODE_UNUSED)
            events_sent++;
        if (ev_mode == MODE_X)
            last_x = ev_value;
        if (ev_mode == MODE_Y)
            last_y = ev_value;
    endtask

    // Advance the event clock: mostly forwards, now and then backwards or
    // to somewhere else entirely, so the gap compare sees every kind of difference
    task automatic advance_time();
        logic [63:0] wide;
        case ($urandom_range(0, 19))
            0, 1:
                ;
            2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                now_us += 40'($urandom_range(0, 1500000));
            13, 14, 15, 16:
                now_us += 40'($urandom_range(0, 20000000));
            17, 18:
                now_us -= 40'($urandom_range(0, 400000));
            default:
            begin
                wide = {$urandom, $urandom};
                now_us = wide[39:0];
            end
        endcase
    endtask

    // Position items carry a junk key code: the block must ignore it
    task automatic move_to(input logic [1:0] axis, input logic [11:0] pos);
        logic [9:0] junk_code;
        junk_code = 10'($urandom_range(0, 767));
        send_event(axis, pos, junk_code, now_us);
    endtask

    task automatic key_event(input logic [9:0] code, input logic [11:0] kval);
        advance_time();
        send_event(MODE_KEY, kval, code, now_us);
    endtask

    // Stay put, jump anywhere, or nudge a little either way
    function automatic logic [11:0] next_position(input logic [11:0] from);
        logic [11:0] nudge;
        nudge = 12'($urandom_range(0, 96));
        case ($urandom_range(0, 3))
            0:       return from;
            1:       return 12'($urandom_range(0, 4095));
            default: return from + nudge - 12'd48;
        endcase
    endfunction

    // Press the pen, wander, release; one in eight leaves the pen held
    task automatic swipe_gesture();
        logic [11:0] level;
        level = 12'($urandom_range(1, 4095));
        if ($urandom_range(0, 3) != 0)
            level = KEY_PRESS;
        key_event(PEN_CODE, level);
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 1))
                move_to(MODE_X, next_position(last_x));
            else
                move_to(MODE_Y, next_position(last_y));
        end
        if ($urandom_range(0, 7) != 0)
            key_event(PEN_CODE, KEY_RELEASE);
    endtask

    // Release on the centre spot or the photo spot, sometimes after drifting off it
    task automatic fixed_point_gesture();
        if ($urandom_range(0, 1)) begin
            move_to(MODE_X, CENTER_POS);
            move_to(MODE_Y, CENTER_POS);
        end else begin
            move_to(MODE_X, PHOTO_X);
            move_to(MODE_Y, PHOTO_Y);
        end
        key_event(PEN_CODE, KEY_PRESS);
        if ($urandom_range(0, 2) == 0)
            move_to(MODE_Y, next_position(last_y));
        key_event(PEN_CODE, KEY_RELEASE);
    endtask

    // Hold the pen on the long column and hit the long-up / long-down rows
    task automatic long_column_gesture();
        move_to(MODE_X, LONG_X);
        key_event(PEN_CODE, KEY_PRESS);
        case ($urandom_range(0, 3))
            0: move_to(MODE_Y, LONG_UP_Y);
            1: move_to(MODE_Y, LONG_DOWN_Y);
            2: move_to(MODE_Y, next_position(last_y));
            default:
            begin
                move_to(MODE_Y, LONG_DOWN_Y);
                move_to(MODE_Y, LONG_UP_Y);
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            move_to(MODE_X, next_position(last_x));
        key_event(PEN_CODE, KEY_RELEASE);
    endtask

    // A run of presses on one volume key, sometimes broken by another key
    task automatic volume_train();
        logic [9:0] code;
        logic [9:0] other;
        code = VOL_DOWN_CODE;
        if ($urandom_range(0, 1))
            code = VOL_UP_CODE;
        repeat ($urandom_range(1, 4)) begin
            key_event(code, KEY_PRESS);
            if ($urandom_range(0, 2) == 0)
                key_event(code, KEY_REPEAT);
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0:       other = VOL_UP_CODE;
                    1:       other = VOL_DOWN_CODE;
                    default: other = 10'($urandom_range(0, 767));
                endcase
                key_event(other, KEY_PRESS);
            end
            key_event(code, KEY_RELEASE);
        end
    endtask

    // Any mode, any value, a code that is sometimes meaningful
    task automatic noise_event();
        logic [9:0]  code;
        logic [1:0]  ev_mode;
        logic [11:0] ev_value;
        case ($urandom_range(0, 3))
            0:       code = PEN_CODE;
            1:       code = VOL_DOWN_CODE;
            2:       code = VOL_UP_CODE;
            default: code = 10'($urandom_range(0, 767));
        endcase
        ev_mode = 2'($urandom_range(0, 3));
        ev_value = 12'($urandom_range(0, 4095));
        if ($urandom_range(0, 1))
            ev_value = 12'($urandom_range(0, 2));
        advance_time();
        send_event(ev_mode, ev_value, code, now_us);
    endtask

    // Drop valid, then wait for every expected action and let the pipe run dry
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [23:0] gap_value);
        cfg_we    <= 1'b1;
        cfg_wdata <= gap_value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: stall for a random spell before each item, and once for a long
    // stretch on request so that the block backs up into its input
    initial begin : action_sink
        int stall_cycles;
        forever begin
            stall_cycles = $urandom_range(0, sink_idle_max);
            if (hold_results) begin
                hold_results = 1'b0;
                stall_cycles += LONG_HOLD_CYCLES;
            end
            if (stall_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin : stimulus
        logic [23:0] gap_value;
        int          target;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, gap register still at its reset value.
        // Enter on the centre spot, photo on the photo spot.
        send_event(MODE_KEY, KEY_PRESS, PEN_CODE, 40'd0);
        send_event(MODE_KEY, KEY_RELEASE, PEN_CODE, 40'd0);
        send_event(MODE_X, PHOTO_X, 10'd0, 40'd0);
        send_event(MODE_Y, PHOTO_Y, 10'd0, 40'd0);
        send_event(MODE_KEY, KEY_PRESS, PEN_CODE, 40'd0);
        send_event(MODE_KEY, KEY_RELEASE, PEN_CODE, 40'd0);
        // X to its top then its bottom: left then right, reversed as the clicker does
        send_event(MODE_KEY, KEY_PRESS, PEN_CODE, 40'd0);
        send_event(MODE_X, 12'hFFF, 10'h3FF, 40'd0);
        send_event(MODE_KEY, KEY_RELEASE, PEN_CODE, 40'd0);
        send_event(MODE_KEY, KEY_PRESS, PEN_CODE, 40'd0);
        send_event(MODE_X, 12'd0, 10'd0, 40'd0);
        send_event(MODE_KEY, KEY_RELEASE, PEN_CODE, 40'd0);
        // Y to its top then its bottom: up then down
        send_event(MODE_KEY, KEY_PRESS, PEN_CODE, 40'd0);
        send_event(MODE_Y, 12'hFFF, 10'd0, 40'd0);
        send_event(MODE_KEY, KEY_RELEASE, PEN_CODE, 40'd0);
        send_event(MODE_KEY, KEY_PRESS, PEN_CODE, 40'd0);
        send_event(MODE_Y, 12'd0, 10'd0, 40'd0);
        send_event(MODE_KEY, KEY_RELEASE, PEN_CODE, 40'd0);
        // Long up and long down on the long column; the release there gives nothing
        send_event(MODE_X, LONG_X, 10'd0, 40'd0);
        send_event(MODE_KEY, KEY_PRESS, PEN_CODE, 40'd0);
        send_event(MODE_Y, LONG_UP_Y, 10'd0, 40'd0);
        send_event(MODE_Y, LONG_DOWN_Y, 10'd0, 40'd0);
        send_event(MODE_KEY, KEY_RELEASE, PEN_CODE, 40'd0);
        // Unused mode with every bit high: swallowed
        send_event(MODE_UNUSED, 12'hFFF, 10'h3FF, 40'hFF_FFFF_FFFF);
        // Volume latches: first press reports, a clock that went back does not,
        // another key clears the latch, and a gap of exactly the register reports again
        send_event(MODE_KEY, KEY_PRESS, VOL_DOWN_CODE, 40'hFF_FFFF_FFFF);
        send_event(MODE_KEY, KEY_PRESS, VOL_DOWN_CODE, 40'd0);
        send_event(MODE_KEY, KEY_PRESS, VOL_UP_CODE, 40'd0);
        send_event(MODE_KEY, KEY_PRESS, VOL_UP_CODE, {16'd0, GAP_RESET});
        now_us = {16'd0, GAP_RESET};

        // Random phases: each one with its own gap setting and idle mix
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0:       gap_value = 24'd0;
                1:       gap_value = 24'hFF_FFFF;
                2:       gap_value = 24'd300000;
                3:       gap_value = GAP_RESET;
                4:       gap_value = 24'($urandom_range(0, 24'hFF_FFFF));
                default: gap_value = 24'd1;
            endcase
            write_gap(gap_value);
            send_idle_max = (phase % 2 == 1) ? 0 : 8;
            sink_idle_max = ((phase / 2) % 2 == 1) ? 0 : 8;
            target = events_sent + RANDOM_EVENTS / PHASES;

            // Back-pressure: hold the result side off for a long stretch and
            // flood enters at full rate until the block stalls its input
            if (phase == 3) begin
                send_idle_max = 0;
                move_to(MODE_X, CENTER_POS);
                move_to(MODE_Y, CENTER_POS);
                hold_results = 1'b1;
                repeat (20) begin
                    key_event(PEN_CODE, KEY_PRESS);
                    key_event(PEN_CODE, KEY_RELEASE);
                end
                send_idle_max = 8;
            end

            while (events_sent < target) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: swipe_gesture();
                    3:       long_column_gesture();
                    4, 5:    fixed_point_gesture();
                    6, 7:    volume_train();
                    default: repeat ($urandom_range(1, 3)) noise_event();
                endcase
            end
        end

        settle();
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cgd_pkg.sv
rtl/core/cgd_front.sv
rtl/core/cgd_queue.sv
rtl/core/cgd_back.sv
rtl/core/clicker_gesture_decoder.sv
tb/sv/cgd_action_checker.sv
tb/sv/testbench.sv
